// ===== rtl/ljpf_pkg.sv =====
// Shared constants, register codes and item types of the Lennard-Jones pair force block.
package ljpf_pkg;

	// Reset values of the configuration registers.
	localparam logic [31:0] BOX_RESET = 32'd167772160;
	localparam logic [63:0] CUT_RESET = 64'd2533274790395904;
	localparam logic signed [47:0] SHIFT_RESET = 48'sd91931;

	// Saturation limits.
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic signed [47:0] POS48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] NEG48 = 48'sh8000_0000_0000;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_BOX   = 2'd0,
		REG_CUT   = 2'd1,
		REG_SHIFT = 2'd2
	} cfg_reg_t;

	// One input item: positions of particles i and j, unsigned Q8.24.
	typedef struct packed {
		logic [31:0] first_x;
		logic [31:0] first_y;
		logic [31:0] first_z;
		logic [31:0] second_x;
		logic [31:0] second_y;
		logic [31:0] second_z;
	} in_item_t;

	// One result item, signed Q24.24 values and two flags.
	typedef struct packed {
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic signed [47:0] pair_energy;
		logic signed [47:0] pair_virial;
		logic               within_cutoff;
		logic               overflow;
	} out_item_t;

endpackage

// ===== rtl/lj_chan_if.sv =====
// Valid/ready channel interface carrying one item of a given type.
interface lj_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ljpf_mul.sv =====
// Two-stage 64 by 64 multiplier giving the product shifted right by 48, saturating.
module ljpf_mul import ljpf_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic        sat_i,
	output logic [63:0] p,
	output logic        sat_o
);

	logic [63:0]  p00_s1, p01_s1, p10_s1, p11_s1;
	logic         sat_s1;
	logic [127:0] full;
	logic [63:0]  prod_s2;
	logic         sat_s2;

	// First stage: four 32 by 32 partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			p01_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			p10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			p11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
			sat_s1 <= sat_i;
		end
	end

	// Combine the partial products into the full 128-bit product.
	assign full = {64'b0, p00_s1} + {32'b0, p01_s1, 32'b0} + {32'b0, p10_s1, 32'b0}
		+ {p11_s1, 64'b0};

	// Second stage: shift by 48 and saturate when high bits remain.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= (|full[127:112]) ? ALL_ONES : full[111:48];
			sat_s2  <= sat_s1 | (|full[127:112]);
		end
	end

	assign p     = prod_s2;
	assign sat_o = sat_s2;

endmodule

// ===== rtl/ljpf_recip.sv =====
// Pipelined reciprocal floor(2^96 / d), one quotient bit per stage, saturating for small d.
module ljpf_recip import ljpf_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] d,
	output logic [63:0] q,
	output logic        sat
);

	localparam int STEPS = 64;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] quo;
		logic [63:0] den;
		logic        tiny;
	} rstage_t;

	rstage_t first;
	rstage_t pipe_s [1:STEPS];

	// One restoring division step.
	function automatic rstage_t step(input rstage_t x);
		logic [64:0] t;
		logic        ge;
		rstage_t     y;
		t = {x.rem, 1'b0};
		ge = t >= {1'b0, x.den};
		y = x;
		y.rem = ge ? 64'(t - {1'b0, x.den}) : t[63:0];
		y.quo = {x.quo[62:0], ge};
		return y;
	endfunction

	// The first 33 steps never subtract since d exceeds 2^32, so the remainder starts there.
	always_comb begin
		first.rem  = 64'h0000_0001_0000_0000;
		first.quo  = '0;
		first.den  = d;
		first.tiny = d <= 64'h0000_0001_0000_0000;
	end

	// Division stages.
	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[1] <= step(first);
			for (int k = 2; k <= STEPS; k++) begin
				pipe_s[k] <= step(pipe_s[k-1]);
			end
		end
	end

	assign q   = pipe_s[STEPS].tiny ? ALL_ONES : pipe_s[STEPS].quo;
	assign sat = pipe_s[STEPS].tiny;

endmodule

// ===== rtl/lj_pair_force.sv =====
// Top level of the Lennard-Jones pair force pipeline with shifted cutoff.
//
//  channel   | direction | contents
//  ----------+-----------+--------------------------------------------------
//  pairs     | in        | positions of particles i and j, unsigned Q8.24
//  results   | out       | forces, energy, virial, cutoff and overflow flags
//  cfg_*     | in        | register writes: box, cutoff squared, energy shift
//
// One item enters per cycle while results is not stalled.
// The pipeline holds the 34-stage minimum-image divider and the 64-stage
// reciprocal, one bit per stage, followed by five two-stage multipliers in series.
// A stall on results freezes the whole pipeline; pairs.ready follows it.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
module lj_pair_force import ljpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lj_chan_if.sink     pairs,
	lj_chan_if.source   results,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// Stage numbers.
	localparam int DIV_N     = 34;
	localparam int REC_N     = 64;
	localparam int S_A       = 1;
	localparam int S_DIV_END = S_A + DIV_N;
	localparam int S_R       = S_DIV_END + 1;
	localparam int S_SQ      = S_R + 1;
	localparam int S_D2      = S_SQ + 1;
	localparam int S_CMP     = S_D2 + 1;
	localparam int S_REC     = S_CMP + REC_N;
	localparam int S_OD2SQ   = S_REC + 2;
	localparam int S_OD6     = S_OD2SQ + 2;
	localparam int S_OD12    = S_OD6 + 2;
	localparam int S_G1      = S_OD12 + 1;
	localparam int S_G2      = S_G1 + 1;
	localparam int S_FC      = S_G2 + 2;
	localparam int S_F       = S_FC + 2;
	localparam int S_OUT     = S_F + 1;

	localparam logic signed [49:0] POS50 = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] NEG50 = 50'sh3_8000_0000_0000;

	typedef struct packed {
		logic [32:0] rem;
		logic [33:0] num;
		logic [31:0] mag;
		logic        neg;
	} dv_t;

	typedef struct packed {
		logic        neg;
		logic [31:0] m;
	} ax_t;

	typedef struct packed {
		logic [2:0]       rneg;
		logic [2:0][31:0] m;
	} trk_t;

	typedef struct packed {
		logic               vneg;
		logic [39:0]        vmh;
		logic signed [47:0] energy;
	} late_t;

	typedef struct packed {
		logic signed [47:0] val;
		logic               sat;
	} cl_t;

	// Configuration registers.
	logic [31:0]        box_q;
	logic [63:0]        cut_q;
	logic signed [47:0] shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q   <= BOX_RESET;
			cut_q   <= CUT_RESET;
			shift_q <= SHIFT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX:   box_q <= cfg_data[31:0];
				REG_CUT:   cut_q <= cfg_data;
				REG_SHIFT: shift_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// Pipeline advance and valid bits.
	logic           en;
	logic [S_OUT:1] v_q;

	assign en          = !v_q[S_OUT] || results.ready;
	assign pairs.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[S_OUT-1:1], pairs.valid};
		end
	end

	// Restoring division step for the minimum-image remainder.
	function automatic dv_t dv_step(input dv_t x, input logic [31:0] l);
		logic [33:0] t;
		logic [33:0] dd;
		logic        ge;
		dv_t         y;
		t = {x.rem, x.num[33]};
		dd = {1'b0, l, 1'b0};
		ge = t >= dd;
		y = x;
		y.rem = ge ? 33'(t - dd) : t[32:0];
		y.num = {x.num[32:0], 1'b0};
		return y;
	endfunction

	// Folded displacement from the remainder: (rem - l) / 2 is mag - q*l.
	function automatic ax_t fold(input dv_t x, input logic [31:0] l);
		logic [34:0] diff;
		logic [33:0] mp;
		logic        mneg;
		logic [31:0] am;
		ax_t         y;
		diff = {2'b0, x.rem} - {3'b0, l};
		mp = diff[34:1];
		if (l == '0) begin
			mneg = 1'b0;
			am = x.mag;
		end else begin
			mneg = diff[34];
			am = mneg ? 32'(~mp + 34'd1) : mp[31:0];
		end
		y.m = am;
		y.neg = (am != '0) && (x.neg ^ mneg);
		return y;
	endfunction

	// Sign and magnitude into the 48-bit output range.
	function automatic cl_t clamp48(input logic neg, input logic [63:0] mag);
		cl_t y;
		y.sat = 1'b0;
		if (neg) begin
			if (mag > 64'h0000_8000_0000_0000) begin
				y.val = NEG48;
				y.sat = 1'b1;
			end else begin
				y.val = 48'(64'd0 - mag);
			end
		end else begin
			if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
				y.val = POS48;
				y.sat = 1'b1;
			end else begin
				y.val = mag[47:0];
			end
		end
		return y;
	endfunction

	// Raw displacement per axis and the rounding numerator 2*|d| + l.
	logic [31:0] pa [3];
	logic [31:0] pb [3];
	dv_t         dv_a [3];

	assign pa[0] = pairs.data.first_x;
	assign pa[1] = pairs.data.first_y;
	assign pa[2] = pairs.data.first_z;
	assign pb[0] = pairs.data.second_x;
	assign pb[1] = pairs.data.second_y;
	assign pb[2] = pairs.data.second_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [32:0] d;
			d = {1'b0, pb[k]} - {1'b0, pa[k]};
			dv_a[k].neg = d[32];
			dv_a[k].mag = d[32] ? 32'(~d + 33'd1) : d[31:0];
			dv_a[k].num = {1'b0, dv_a[k].mag, 1'b0} + {2'b0, box_q};
			dv_a[k].rem = '0;
		end
	end

	// Minimum-image divider stages, three axes side by side.
	dv_t dv_s [S_A:S_DIV_END][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_s[S_A][k] <= dv_a[k];
				for (int s = S_A + 1; s <= S_DIV_END; s++) begin
					dv_s[s][k] <= dv_step(dv_s[s-1][k], box_q);
				end
			end
		end
	end

	// Folded axis magnitudes and signs, carried to the force stage.
	trk_t trk_new;
	trk_t trk_s [S_R:S_F];
	logic win_s [S_CMP:S_F];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ax_t ax;
			ax = fold(dv_s[S_DIV_END][k], box_q);
			trk_new.rneg[k] = ax.neg;
			trk_new.m[k] = ax.m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trk_s[S_R] <= trk_new;
			for (int s = S_R + 1; s <= S_F; s++) begin
				trk_s[s] <= trk_s[s-1];
			end
			for (int s = S_CMP + 1; s <= S_F; s++) begin
				win_s[s] <= win_s[s-1];
			end
		end
	end

	// Squares, saturating sum and cutoff compare.
	logic [63:0] sq_s37 [3];
	logic [65:0] sum;
	logic [63:0] d2_s38;
	logic [63:0] d2_s39;

	assign sum = 66'(sq_s37[0]) + 66'(sq_s37[1]) + 66'(sq_s37[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s37[k] <= 64'(trk_s[S_R].m[k]) * 64'(trk_s[S_R].m[k]);
			end
			d2_s38       <= (|sum[65:64]) ? ALL_ONES : sum[63:0];
			d2_s39       <= d2_s38;
			win_s[S_CMP] <= d2_s38 < cut_q;
		end
	end

	// Reciprocal of the squared distance.
	logic [63:0] od2;
	logic        od2_sat;

	ljpf_recip u_recip (
		.clk (clk),
		.en  (en),
		.d   (d2_s39),
		.q   (od2),
		.sat (od2_sat)
	);

	logic [63:0] od2_s [S_REC+1:S_G2];

	always_ff @(posedge clk) begin
		if (en) begin
			od2_s[S_REC+1] <= od2;
			for (int s = S_REC + 2; s <= S_G2; s++) begin
				od2_s[s] <= od2_s[s-1];
			end
		end
	end

	// Powers od2^2, od6 and od12.
	logic [63:0] od2sq, od6, od12;
	logic        od2sq_sat, od6_sat, od12_sat;

	ljpf_mul u_mul_sq (
		.clk (clk), .en (en), .a (od2), .b (od2), .sat_i (od2_sat),
		.p (od2sq), .sat_o (od2sq_sat)
	);

	ljpf_mul u_mul_6 (
		.clk (clk), .en (en), .a (od2sq), .b (od2_s[S_OD2SQ]), .sat_i (od2sq_sat),
		.p (od6), .sat_o (od6_sat)
	);

	ljpf_mul u_mul_12 (
		.clk (clk), .en (en), .a (od6), .b (od6), .sat_i (od6_sat),
		.p (od12), .sat_o (od12_sat)
	);

	logic [63:0] od6_s [S_OD6+1:S_OD12];

	always_ff @(posedge clk) begin
		if (en) begin
			od6_s[S_OD6+1] <= od6;
			for (int s = S_OD6 + 2; s <= S_OD12; s++) begin
				od6_s[s] <= od6_s[s-1];
			end
		end
	end

	// First combine stage: energy and virial differences.
	logic [41:0] em_s110;
	logic        eneg_s110, esat_s110, vbig_s110, vn_s110, sat_s110;
	logic [63:0] vdiff_s110;
	logic [63:0] od6_c, ediff, vt;
	logic        eneg_c, vn_c;

	assign od6_c  = od6_s[S_OD12];
	assign eneg_c = od12 < od6_c;
	assign ediff  = eneg_c ? od6_c - od12 : od12 - od6_c;
	assign vt     = {od12[62:0], 1'b0};
	assign vn_c   = vt > od6_c;

	always_ff @(posedge clk) begin
		if (en) begin
			em_s110    <= ediff[63:22];
			eneg_s110  <= eneg_c;
			esat_s110  <= (od12 == ALL_ONES) && od12_sat;
			vbig_s110  <= od12[63];
			vn_s110    <= vn_c;
			vdiff_s110 <= vn_c ? vt - od6_c : od6_c - vt;
			sat_s110   <= od12_sat;
		end
	end

	// Second combine stage: shifted energy and virial magnitude 24 * diff.
	logic signed [49:0] e_c;
	logic [68:0]        p24;
	logic signed [47:0] energy_s111;
	logic               vneg_s111, sat_s111;
	logic [63:0]        vmag_s111;
	logic               esat_c, vsat_c;
	logic signed [47:0] energy_c;
	logic [63:0]        vmag_c;

	assign p24 = {1'b0, vdiff_s110, 4'b0} + {2'b0, vdiff_s110, 3'b0};

	always_comb begin
		e_c = eneg_s110 ? {{2{shift_q[47]}}, shift_q} - {8'b0, em_s110}
			: {{2{shift_q[47]}}, shift_q} + {8'b0, em_s110};
		esat_c = 1'b0;
		if (esat_s110) begin
			energy_c = POS48;
		end else if (e_c > POS50) begin
			energy_c = POS48;
			esat_c = 1'b1;
		end else if (e_c < NEG50) begin
			energy_c = NEG48;
			esat_c = 1'b1;
		end else begin
			energy_c = e_c[47:0];
		end
		if (vbig_s110 || (|p24[68:64])) begin
			vmag_c = ALL_ONES;
			vsat_c = 1'b1;
		end else begin
			vmag_c = p24[63:0];
			vsat_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			energy_s111 <= energy_c;
			vneg_s111   <= vbig_s110 || vn_s110;
			vmag_s111   <= vmag_c;
			sat_s111    <= sat_s110 | esat_c | vsat_c;
		end
	end

	// Energy, virial sign and magnitude wait for the forces.
	late_t late_s [S_G2+1:S_F];

	always_ff @(posedge clk) begin
		if (en) begin
			late_s[S_G2+1] <= '{vneg: vneg_s111, vmh: vmag_s111[63:24], energy: energy_s111};
			for (int s = S_G2 + 2; s <= S_F; s++) begin
				late_s[s] <= late_s[s-1];
			end
		end
	end

	// Force coefficient and per-axis force magnitudes.
	logic [63:0] fc;
	logic        fc_sat;
	logic [63:0] fm [3];
	logic [2:0]  fm_sat;

	ljpf_mul u_mul_fc (
		.clk (clk), .en (en), .a (vmag_s111), .b (od2_s[S_G2]), .sat_i (sat_s111),
		.p (fc), .sat_o (fc_sat)
	);

	for (genvar k = 0; k < 3; k++) begin : g_force
		ljpf_mul u_mul_f (
			.clk   (clk),
			.en    (en),
			.a     ({32'b0, trk_s[S_FC].m[k]}),
			.b     (fc),
			.sat_i ((k == 0) ? fc_sat : 1'b0),
			.p     (fm[k]),
			.sat_o (fm_sat[k])
		);
	end

	// Output stage: clamps, overflow and the zero result outside the cutoff.
	out_item_t out_c;
	out_item_t out_s116;

	always_comb begin
		cl_t cf [3];
		cl_t cv;
		for (int k = 0; k < 3; k++) begin
			cf[k] = clamp48(trk_s[S_F].rneg[k] != late_s[S_F].vneg, fm[k]);
		end
		cv = clamp48(late_s[S_F].vneg, {24'b0, late_s[S_F].vmh});
		out_c = '0;
		if (win_s[S_F]) begin
			out_c.force_x       = cf[0].val;
			out_c.force_y       = cf[1].val;
			out_c.force_z       = cf[2].val;
			out_c.pair_energy   = late_s[S_F].energy;
			out_c.pair_virial   = cv.val;
			out_c.within_cutoff = 1'b1;
			out_c.overflow      = (|fm_sat) | cf[0].sat | cf[1].sat | cf[2].sat | cv.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s116 <= out_c;
		end
	end

	assign results.valid = v_q[S_OUT];
	assign results.data  = out_s116;

	// A pair outside the cutoff gives an all-zero result.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.data.within_cutoff |->
			results.data.force_x == '0 && results.data.force_y == '0 &&
			results.data.force_z == '0 && results.data.pair_energy == '0 &&
			results.data.pair_virial == '0 && !results.data.overflow)
		else $error("non-zero result outside the cutoff");

	// A stalled pipeline keeps every valid bit in place.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q))
		else $error("pipeline valid bits moved during a stall");

	// The virial magnitude never exceeds 2^40 - 1.
	a_virial_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |->
			results.data.pair_virial[47:40] == {8{results.data.pair_virial[47]}})
		else $error("virial outside its reachable range");

endmodule
